>>> rtl/accelerometer_tilt_angles_assert.svh
// Assertion macros for the tilt angle block.
`ifndef ACCELEROMETER_TILT_ANGLES_ASSERT_SVH
`define ACCELEROMETER_TILT_ANGLES_ASSERT_SVH
`ifndef SYNTH
`define TILT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define TILT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define TILT_ASSERT(lbl, prop, msg)
`define TILT_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/tilt_pkg.sv
package tilt_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int NSTEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    localparam int NORM_W = 8 + FRAC_BITS;   // magnitude bits of a normalized axis
    localparam int CW     = NORM_W + 4;      // CORDIC x/y width, signed
    localparam int ANG_W  = 35;              // angle, radians * 2^30, signed
    localparam int CNT_W  = 5;
    localparam int MUL_STEPS = 30;

    localparam logic [29:0] INV_GAIN = 30'd652032874;
    localparam logic signed [ANG_W-1:0] ANG_PI = 35'sd3373259426;

    localparam logic [2:0] REG_ZERO_X = 3'd0;
    localparam logic [2:0] REG_ZERO_Y = 3'd1;
    localparam logic [2:0] REG_ZERO_Z = 3'd2;
    localparam logic [2:0] REG_ONE_X  = 3'd3;
    localparam logic [2:0] REG_ONE_Y  = 3'd4;
    localparam logic [2:0] REG_ONE_Z  = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_CHECK,
        ST_ROLL_PRE,
        ST_ROLL,
        ST_MUL,
        ST_PITCH_PRE,
        ST_PITCH,
        ST_SCALE1,
        ST_SCALE2,
        ST_SCALE3,
        ST_DONE
    } state_t;

    function automatic logic [29:0] atan_entry(logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/accelerometer_tilt_angles.sv
// Tilt angles from one three-axis accelerometer sample. One sample is taken at a time:
// each axis is normalized by a bit-serial divider (a load state, then one quotient bit
// per cycle), then roll and pitch come from one shared CORDIC vectoring unit (a setup
// state, then a rotation state, for each angle) with a bit-serial gain correction
// between them and the scaling states ST_SCALE1 to ST_SCALE3 after them. When
// normalized z is zero, the CORDIC is skipped and the held angles are re-sent. The
// input is ready again in the same cycle that the result is presented. A finished
// result waits in an output register, so the next sample is accepted while it is
// pending; a second result waits in the done state until the first one is taken.
`include "accelerometer_tilt_angles_assert.svh"

module accelerometer_tilt_angles (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // acc_x, acc_y, acc_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // raw_x, raw_y, raw_z, roll_angle[14], pitch_angle[12]
    output logic        m_tuser,    // angles_updated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NW = tilt_pkg::NORM_W;
    localparam int CW = tilt_pkg::CW;
    localparam int AW = tilt_pkg::ANG_W;

    tilt_pkg::state_t state_reg, state_next;

    logic [7:0] zero_x_reg, zero_y_reg, zero_z_reg, one_x_reg, one_y_reg, one_z_reg;

    logic [7:0] raw_x_reg, raw_x_next, raw_y_reg, raw_y_next, raw_z_reg, raw_z_next;
    logic [1:0] axis_reg, axis_next;
    logic [tilt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] dvd_reg, dvd_next;
    logic [7:0] rem_reg, rem_next, den_reg, den_next;
    logic qneg_reg, qneg_next, dzero_reg, dzero_next, nzero_reg, nzero_next;
    logic signed [NW:0] norm_x_reg, norm_x_next, norm_y_reg, norm_y_next;
    logic signed [NW:0] norm_z_reg, norm_z_next;
    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [AW-1:0] ang_reg, ang_next, roll_ang_reg, roll_ang_next;
    logic [CW-1:0] acc_reg, acc_next;
    logic [46:0] rprod_reg, rprod_next;
    logic [41:0] pprod_reg, pprod_next;
    logic [32:0] rq_reg, rq_next;
    logic [11:0] pmag_reg, pmag_next;
    logic signed [13:0] held_roll_reg, held_roll_next;
    logic signed [11:0] held_pitch_reg, held_pitch_next;
    logic upd_reg, upd_next;
    logic m_valid_reg, m_valid_next;
    logic [55:0] out_data_reg, out_data_next;
    logic out_user_reg, out_user_next;

    logic cfg_wr, out_free;
    logic last_div, last_cordic, last_mul;

    // axis select and divider step
    logic [7:0] sel_raw, sel_zero, sel_one;
    logic signed [8:0] num, den;
    logic [7:0] num_abs, den_abs;
    logic [8:0] div_trial;
    logic div_ge;
    logic [NW-1:0] q_dvd, q_mag;
    logic signed [NW:0] q_val;

    // CORDIC
    logic signed [CW-1:0] pre_x, pre_y, pre_cx, pre_cy, dx, dy, st_cx, st_cy;
    logic signed [AW-1:0] pre_ang, st_ang, tab;
    logic [CW:0] acc_sum;

    // scaling
    logic [AW-1:0] roll_abs, pitch_abs;
    logic [14:0] rmag, rmag_c;
    logic [11:0] pmag_c;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign s_tready = (state_reg == tilt_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_x_reg <= 8'd128;
            zero_y_reg <= 8'd128;
            zero_z_reg <= 8'd128;
            one_x_reg  <= 8'd154;
            one_y_reg  <= 8'd154;
            one_z_reg  <= 8'd154;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                tilt_pkg::REG_ZERO_X: zero_x_reg <= pwdata[7:0];
                tilt_pkg::REG_ZERO_Y: zero_y_reg <= pwdata[7:0];
                tilt_pkg::REG_ZERO_Z: zero_z_reg <= pwdata[7:0];
                tilt_pkg::REG_ONE_X:  one_x_reg  <= pwdata[7:0];
                tilt_pkg::REG_ONE_Y:  one_y_reg  <= pwdata[7:0];
                tilt_pkg::REG_ONE_Z:  one_z_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            tilt_pkg::REG_ZERO_X: prdata = {24'd0, zero_x_reg};
            tilt_pkg::REG_ZERO_Y: prdata = {24'd0, zero_y_reg};
            tilt_pkg::REG_ZERO_Z: prdata = {24'd0, zero_z_reg};
            tilt_pkg::REG_ONE_X:  prdata = {24'd0, one_x_reg};
            tilt_pkg::REG_ONE_Y:  prdata = {24'd0, one_y_reg};
            tilt_pkg::REG_ONE_Z:  prdata = {24'd0, one_z_reg};
            default:              prdata = 32'd0;
        endcase
    end

    assign last_div    = (cnt_reg == tilt_pkg::CNT_W'(NW - 1));
    assign last_cordic = (cnt_reg == tilt_pkg::CNT_W'(tilt_pkg::NSTEPS - 1));
    assign last_mul    = (cnt_reg == tilt_pkg::CNT_W'(tilt_pkg::MUL_STEPS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tilt_pkg::ST_IDLE:      if (s_tvalid) state_next = tilt_pkg::ST_LOAD;
            tilt_pkg::ST_LOAD:      state_next = tilt_pkg::ST_DIV;
            tilt_pkg::ST_DIV: begin
                if (last_div) begin
                    state_next = (axis_reg == tilt_pkg::AXIS_Z) ? tilt_pkg::ST_CHECK
                                                                : tilt_pkg::ST_LOAD;
                end
            end
            tilt_pkg::ST_CHECK: begin
                state_next = (norm_z_reg == '0) ? tilt_pkg::ST_DONE : tilt_pkg::ST_ROLL_PRE;
            end
            tilt_pkg::ST_ROLL_PRE:  state_next = tilt_pkg::ST_ROLL;
            tilt_pkg::ST_ROLL:      if (last_cordic) state_next = tilt_pkg::ST_MUL;
            tilt_pkg::ST_MUL:       if (last_mul) state_next = tilt_pkg::ST_PITCH_PRE;
            tilt_pkg::ST_PITCH_PRE: state_next = tilt_pkg::ST_PITCH;
            tilt_pkg::ST_PITCH:     if (last_cordic) state_next = tilt_pkg::ST_SCALE1;
            tilt_pkg::ST_SCALE1:    state_next = tilt_pkg::ST_SCALE2;
            tilt_pkg::ST_SCALE2:    state_next = tilt_pkg::ST_SCALE3;
            tilt_pkg::ST_SCALE3:    state_next = tilt_pkg::ST_DONE;
            tilt_pkg::ST_DONE:      if (out_free) state_next = tilt_pkg::ST_IDLE;
            default:                state_next = tilt_pkg::ST_IDLE;
        endcase
    end

    // divider
    always_comb begin
        unique case (axis_reg)
            tilt_pkg::AXIS_X: begin sel_raw = raw_x_reg; sel_zero = zero_x_reg; sel_one = one_x_reg; end
            tilt_pkg::AXIS_Y: begin sel_raw = raw_y_reg; sel_zero = zero_y_reg; sel_one = one_y_reg; end
            default:          begin sel_raw = raw_z_reg; sel_zero = zero_z_reg; sel_one = one_z_reg; end
        endcase
        num = $signed({1'b0, sel_raw}) - $signed({1'b0, sel_zero});
        den = $signed({1'b0, sel_one}) - $signed({1'b0, sel_zero});
        num_abs = num[8] ? 8'(-num) : num[7:0];
        den_abs = den[8] ? 8'(-den) : den[7:0];
        div_trial = {rem_reg, dvd_reg[NW-1]};
        div_ge = (div_trial >= {1'b0, den_reg});
        q_dvd  = {dvd_reg[NW-2:0], div_ge};
        if (dzero_reg) begin
            q_mag = nzero_reg ? '0 : '1;
        end else begin
            q_mag = q_dvd;
        end
        q_val = qneg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    end

    // CORDIC pre-rotation and step
    always_comb begin
        if (state_reg == tilt_pkg::ST_ROLL_PRE) begin
            pre_x = CW'(norm_z_reg);
            pre_y = CW'(norm_x_reg);
        end else begin
            pre_x = $signed(acc_reg);
            pre_y = CW'(norm_y_reg);
        end
        if (pre_x < 0) begin
            pre_ang = (pre_y > 0) ? tilt_pkg::ANG_PI : -tilt_pkg::ANG_PI;
            pre_cx  = -pre_x;
            pre_cy  = -pre_y;
        end else begin
            pre_ang = '0;
            pre_cx  = pre_x;
            pre_cy  = pre_y;
        end
        dx  = cy_reg >>> cnt_reg;
        dy  = cx_reg >>> cnt_reg;
        tab = $signed({5'd0, tilt_pkg::atan_entry(cnt_reg)});
        if (cy_reg > 0) begin
            st_cx  = cx_reg + dx;
            st_cy  = cy_reg - dy;
            st_ang = ang_reg + tab;
        end else begin
            st_cx  = cx_reg - dx;
            st_cy  = cy_reg + dy;
            st_ang = ang_reg - tab;
        end
        acc_sum = {1'b0, acc_reg} + (tilt_pkg::INV_GAIN[cnt_reg] ? {1'b0, cx_reg} : '0);
    end

    // scaling
    always_comb begin
        roll_abs  = roll_ang_reg[AW-1] ? AW'(-roll_ang_reg) : roll_ang_reg;
        pitch_abs = ang_reg[AW-1] ? AW'(-ang_reg) : ang_reg;
        rmag   = rq_reg[32:18];
        rmag_c = (rmag > 15'd4440) ? 15'd4440 : rmag;
        pmag_c = (pmag_reg > 12'd1484) ? 12'd1484 : pmag_reg;
    end

    always_comb begin
        raw_x_next = raw_x_reg;  raw_y_next = raw_y_reg;  raw_z_next = raw_z_reg;
        axis_next = axis_reg;    cnt_next = cnt_reg;
        dvd_next = dvd_reg;      rem_next = rem_reg;      den_next = den_reg;
        qneg_next = qneg_reg;    dzero_next = dzero_reg;  nzero_next = nzero_reg;
        norm_x_next = norm_x_reg; norm_y_next = norm_y_reg; norm_z_next = norm_z_reg;
        cx_next = cx_reg;        cy_next = cy_reg;        ang_next = ang_reg;
        roll_ang_next = roll_ang_reg;
        acc_next = acc_reg;
        rprod_next = rprod_reg;  pprod_next = pprod_reg;
        rq_next = rq_reg;        pmag_next = pmag_reg;
        held_roll_next = held_roll_reg;
        held_pitch_next = held_pitch_reg;
        upd_next = upd_reg;
        m_valid_next = m_valid_reg && !m_tready;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        unique case (state_reg)
            tilt_pkg::ST_IDLE: begin
                raw_x_next = s_tdata[7:0];
                raw_y_next = s_tdata[15:8];
                raw_z_next = s_tdata[23:16];
                axis_next  = tilt_pkg::AXIS_X;
            end
            tilt_pkg::ST_LOAD: begin
                dvd_next   = {num_abs, {tilt_pkg::FRAC_BITS{1'b0}}};
                rem_next   = '0;
                den_next   = den_abs;
                qneg_next  = num[8] ^ den[8];
                dzero_next = (den == 0);
                nzero_next = (num == 0);
                cnt_next   = '0;
            end
            tilt_pkg::ST_DIV: begin
                rem_next = div_ge ? 8'(div_trial - {1'b0, den_reg}) : div_trial[7:0];
                dvd_next = q_dvd;
                cnt_next = cnt_reg + 1'b1;
                if (last_div) begin
                    unique case (axis_reg)
                        tilt_pkg::AXIS_X: norm_x_next = q_val;
                        tilt_pkg::AXIS_Y: norm_y_next = q_val;
                        default:          norm_z_next = q_val;
                    endcase
                    axis_next = axis_reg + 1'b1;
                end
            end
            tilt_pkg::ST_CHECK: upd_next = 1'b0;
            tilt_pkg::ST_ROLL_PRE, tilt_pkg::ST_PITCH_PRE: begin
                cx_next  = pre_cx;
                cy_next  = pre_cy;
                ang_next = pre_ang;
                cnt_next = '0;
            end
            tilt_pkg::ST_ROLL, tilt_pkg::ST_PITCH: begin
                cx_next  = st_cx;
                cy_next  = st_cy;
                ang_next = st_ang;
                cnt_next = cnt_reg + 1'b1;
                if (last_cordic) begin
                    cnt_next = '0;
                    acc_next = '0;
                    if (state_reg == tilt_pkg::ST_ROLL) roll_ang_next = st_ang;
                end
            end
            tilt_pkg::ST_MUL: begin
                acc_next = acc_sum[CW:1];
                cnt_next = cnt_reg + 1'b1;
            end
            tilt_pkg::ST_SCALE1: begin
                rprod_next = ({14'd0, roll_abs[32:0]} * 47'd4704) + (47'd5 << 29);
                pprod_next = ({11'd0, pitch_abs[30:0]} * 42'd944) + (42'd1 << 29);
            end
            tilt_pkg::ST_SCALE2: begin
                rq_next   = {16'd0, rprod_reg[46:30]} * 33'd52429;
                pmag_next = pprod_reg[41:30];
            end
            tilt_pkg::ST_SCALE3: begin
                held_roll_next  = roll_ang_reg[AW-1] ? -$signed(14'(rmag_c))
                                                     : $signed(14'(rmag_c));
                held_pitch_next = ang_reg[AW-1] ? $signed(pmag_c) : -$signed(pmag_c);
                upd_next = 1'b1;
            end
            tilt_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_data_next = {6'd0, held_pitch_reg, held_roll_reg,
                                     raw_z_reg, raw_y_reg, raw_x_reg};
                    out_user_next = upd_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tilt_pkg::ST_IDLE;
            held_roll_reg  <= '0;
            held_pitch_reg <= '0;
            m_valid_reg    <= 1'b0;
            axis_reg       <= '0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            held_roll_reg  <= held_roll_next;
            held_pitch_reg <= held_pitch_next;
            m_valid_reg    <= m_valid_next;
            axis_reg       <= axis_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_x_reg <= raw_x_next;  raw_y_reg <= raw_y_next;  raw_z_reg <= raw_z_next;
        dvd_reg <= dvd_next;      rem_reg <= rem_next;      den_reg <= den_next;
        qneg_reg <= qneg_next;    dzero_reg <= dzero_next;  nzero_reg <= nzero_next;
        norm_x_reg <= norm_x_next; norm_y_reg <= norm_y_next; norm_z_reg <= norm_z_next;
        cx_reg <= cx_next;        cy_reg <= cy_next;        ang_reg <= ang_next;
        roll_ang_reg <= roll_ang_next;
        acc_reg <= acc_next;
        rprod_reg <= rprod_next;  pprod_reg <= pprod_next;
        rq_reg <= rq_next;        pmag_reg <= pmag_next;
        upd_reg <= upd_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    `TILT_ASSERT(a_roll_range, (held_roll_reg <= 14'sd4440) && (held_roll_reg >= -14'sd4440), "roll out of range")
    `TILT_ASSERT(a_hold_on_zero_z, (state_reg == tilt_pkg::ST_CHECK && norm_z_reg == '0) |=> ($stable(held_roll_reg) && $stable(held_pitch_reg)), "held angles changed")
    `TILT_NEVER(a_div_cnt, state_reg == tilt_pkg::ST_DIV && cnt_reg >= tilt_pkg::CNT_W'(NW), "divider overran")

endmodule
